FILE: src/tbcc_pkg.sv
package tbcc_pkg;

    localparam int MAX_MSG_BITS = 48;
    localparam int CRC_BITS     = 16;
    localparam int MIN_MSG_BITS = 6;
    localparam int TB_BITS      = 6;
    localparam int LEN_W        = 6;
    localparam int IDX_W        = 6;

    localparam logic [CRC_BITS-1:0] CRC16_POLY = 16'h1021;
    localparam logic [6:0]          GEN_A      = 7'o133;
    localparam logic [6:0]          GEN_B      = 7'o171;
    localparam logic [6:0]          GEN_C      = 7'o165;

    typedef struct packed {
        logic [MAX_MSG_BITS-1:0] message_bits;
        logic [LEN_W-1:0]        message_length;
        logic                    attach_crc;
        logic [CRC_BITS-1:0]     rnti_mask;
    } in_item_t;

    typedef struct packed {
        logic code_bit_a;
        logic code_bit_b;
        logic code_bit_c;
        logic last_of_block;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic crc_step;
        logic preload;
        logic enc_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic crc_done;
        logic enc_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: src/tbcc_ctrl.sv
module tbcc_ctrl
    import tbcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CRC     = 2'd1;
    localparam logic [1:0] ST_PRELOAD = 2'd2;
    localparam logic [1:0] ST_ENC     = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (sts.crc_done)
                    state_next = ST_PRELOAD;
            end
            ST_PRELOAD:
            begin
                cmd.preload = 1'b1;
                state_next  = ST_ENC;
            end
            ST_ENC:
            begin
                if (sts.out_free)
                begin
                    cmd.enc_step = 1'b1;
                    if (sts.enc_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: src/tbcc_datapath.sv
module tbcc_datapath
    import tbcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [MAX_MSG_BITS-1:0] msg_reg;
    logic [MAX_MSG_BITS-1:0] scan_reg;
    logic [CRC_BITS-1:0]     crc_reg;
    logic [CRC_BITS-1:0]     rnti_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    crc_on_reg;
    logic [TB_BITS-1:0]      tail_reg;
    logic [TB_BITS-1:0]      win_reg;
    logic [IDX_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        last_idx_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic [LEN_W-1:0]    len_clamped;
    logic                crc_in_bit;
    logic                crc_fb;
    logic [CRC_BITS-1:0] crc_shifted;
    logic [CRC_BITS-1:0] crc_masked;
    logic [TB_BITS-1:0]  crc_tail;
    logic                in_msg;
    logic                enc_bit;
    logic [6:0]          window;
    logic [IDX_W:0]      total_ext;
    logic                out_free;

    always_comb
    begin
        if (in_data.message_length > LEN_W'(MAX_MSG_BITS))
            len_clamped = LEN_W'(MAX_MSG_BITS);
        else if (in_data.message_length < LEN_W'(MIN_MSG_BITS))
            len_clamped = LEN_W'(MIN_MSG_BITS);
        else
            len_clamped = in_data.message_length;
    end

    assign crc_in_bit  = scan_reg[MAX_MSG_BITS-1];
    assign crc_fb      = crc_reg[CRC_BITS-1] ^ crc_in_bit;
    assign crc_shifted = {crc_reg[CRC_BITS-2:0], 1'b0} ^ (crc_fb ? CRC16_POLY : '0);
    assign crc_masked  = crc_reg ^ rnti_reg;

    // tail state: bit 5 is the final sequence bit (crc bit 0)
    always_comb
    begin
        for (int i = 0; i < TB_BITS; i++)
            crc_tail[i] = crc_masked[TB_BITS-1-i];
    end

    assign in_msg  = ({1'b0, cnt_reg} < {1'b0, len_reg});
    assign enc_bit = in_msg ? msg_reg[MAX_MSG_BITS-1] : crc_reg[CRC_BITS-1];
    assign window  = {enc_bit, win_reg};

    assign total_ext = {1'b0, len_reg} + (crc_on_reg ? (IDX_W+1)'(CRC_BITS) : '0)
                       - (IDX_W+1)'(1);

    assign out_free = !out_valid_reg || out_ready;

    assign sts.crc_done = (cnt_reg == (len_reg - LEN_W'(1)));
    assign sts.enc_last = (cnt_reg == last_idx_reg);
    assign sts.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            msg_reg    <= in_data.message_bits;
            scan_reg   <= in_data.message_bits;
            rnti_reg   <= in_data.rnti_mask;
            len_reg    <= len_clamped;
            crc_on_reg <= in_data.attach_crc;
            crc_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (cmd.crc_step)
        begin
            scan_reg <= {scan_reg[MAX_MSG_BITS-2:0], 1'b0};
            crc_reg  <= crc_shifted;
            tail_reg <= {crc_in_bit, tail_reg[TB_BITS-1:1]};
            cnt_reg  <= cnt_reg + IDX_W'(1);
        end
        else if (cmd.preload)
        begin
            last_idx_reg <= total_ext[IDX_W-1:0];
            cnt_reg      <= '0;
            if (crc_on_reg)
            begin
                crc_reg <= crc_masked;
                win_reg <= crc_tail;
            end
            else
            begin
                win_reg <= tail_reg;
            end
        end
        else if (cmd.enc_step)
        begin
            if (in_msg)
                msg_reg <= {msg_reg[MAX_MSG_BITS-2:0], 1'b0};
            else
                crc_reg <= {crc_reg[CRC_BITS-2:0], 1'b0};
            win_reg <= window[6:1];
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enc_step)
        begin
            out_reg.code_bit_a    <= ^(window & GEN_A);
            out_reg.code_bit_b    <= ^(window & GEN_B);
            out_reg.code_bit_c    <= ^(window & GEN_C);
            out_reg.last_of_block <= (cnt_reg == last_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.enc_step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: src/tail_biting_conv_encoder_crc.sv
// Processing: a bit-serial CRC over the len message bits, one preload step, then
// the encoder; each triple is registered from its encode step.
// A new item is accepted only in idle, after the last triple of the previous item,
// with one CRC bit per cycle and one triple per cycle while out_ready does not stall.
// Reset: rst_n asynchronous, active low; clears controller state and output valid.
module tail_biting_conv_encoder_crc
    import tbcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    tbcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tbcc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: verif/tail_biting_conv_encoder_crc_test.sv
`timescale 1ns / 100ps

module tail_biting_conv_encoder_crc_test
    import tbcc_pkg::*;
();

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 190;
    localparam int QUIET_ITEMS   = 30;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT       = 1500;
    localparam int DRAIN_CYCLES  = 150;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        in_item_t item;
        bit       drain_first;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    pending_t  pending_items[$];
    out_item_t expected_triples[$];

    int  triples_predicted = 0;
    int  triples_checked = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  mismatches = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    bit  hold_done = 1'b0;
    bit  quiet_tail = 1'b0;
    bit  inputs_done = 1'b0;

    tail_biting_conv_encoder_crc i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // CRC16 over the message, masked CRC appended when attach_crc is set, tail-biting K=7 rate-1/3 code
    function automatic int encode_block(input in_item_t it);
        int          len;
        int          total;
        int          i;
        logic [15:0] crc;
        logic [63:0] seq;
        logic [6:0]  win;
        logic        fb;
        out_item_t   t;
        len = int'(it.message_length);
        if (len > MAX_MSG_BITS)
            len = MAX_MSG_BITS;
        if (len < MIN_MSG_BITS)
            len = MIN_MSG_BITS;
        crc = '0;
        seq = '0;
        for (i = 0; i < len; i++)
        begin
            seq[i] = it.message_bits[MAX_MSG_BITS-1-i];
            fb = crc[15] ^ seq[i];
            crc = crc << 1;
            if (fb)
                crc = crc ^ CRC16_POLY;
        end
        total = len;
        if (it.attach_crc)
        begin
            crc = crc ^ it.rnti_mask;
            for (i = 0; i < CRC_BITS; i++)
                seq[total+i] = crc[CRC_BITS-1-i];
            total = total + CRC_BITS;
        end
        win = '0;
        for (i = 0; i < TB_BITS; i++)
            win[i] = seq[total-TB_BITS+i];
        for (i = 0; i < total; i++)
        begin
            win[6] = seq[i];
            t.code_bit_a    = ^(win & GEN_A);
            t.code_bit_b    = ^(win & GEN_B);
            t.code_bit_c    = ^(win & GEN_C);
            t.last_of_block = (i == total - 1);
            expected_triples.push_back(t);
            win = win >> 1;
        end
        return total;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 8;
            default: return 30;
        endcase
    endfunction

    task automatic add_item(input logic [47:0] msg, input int len, input bit crc_on,
                            input logic [15:0] rnti, input bit drain);
        pending_t p;
        p.item.message_bits   = msg;
        p.item.message_length = len[LEN_W-1:0];
        p.item.attach_crc     = crc_on;
        p.item.rnti_mask      = rnti;
        p.drain_first         = drain;
        pending_items.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic     nxt_valid;
        in_item_t nxt_data;
        pending_t p;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            in_data     <= '0;
            quiet_tail  <= 1'b0;
            inputs_done <= 1'b0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            if (in_valid && in_ready)
            begin
                triples_predicted += encode_block(in_data);
                items_sent++;
                if (items_sent % 16 == 0)
                    tx_idle_pct = pick_idle_pct();
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (tx_gap != 0)
                    tx_gap--;
                else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain_first &&
                           triples_checked != triples_predicted))
                begin
                    if (!quiet_tail && hold_left == 0 &&
                        $urandom_range(0, 99) < tx_idle_pct)
                        tx_gap = $urandom_range(1, 19) - 1;
                    else
                    begin
                        p = pending_items.pop_front();
                        nxt_data  = p.item;
                        nxt_valid = 1'b1;
                    end
                end
            end
            in_valid    <= nxt_valid;
            in_data     <= nxt_data;
            quiet_tail  <= (pending_items.size() < QUIET_ITEMS);
            inputs_done <= (pending_items.size() == 0 && !nxt_valid);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (results_seen % 64 == 0)
                    rx_idle_pct = pick_idle_pct();
                if (expected_triples.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected triple a=%b b=%b c=%b last=%b",
                                 out_data.code_bit_a, out_data.code_bit_b,
                                 out_data.code_bit_c, out_data.last_of_block);
                    mismatches++;
                end
                else
                begin
                    want = expected_triples.pop_front();
                    if (out_data.code_bit_a !== want.code_bit_a ||
                        out_data.code_bit_b !== want.code_bit_b ||
                        out_data.code_bit_c !== want.code_bit_c ||
                        out_data.last_of_block !== want.last_of_block)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display(
                                "triple %0d: expected abcl=%b%b%b%b, got abcl=%b%b%b%b",
                                results_seen, want.code_bit_a, want.code_bit_b,
                                want.code_bit_c, want.last_of_block,
                                out_data.code_bit_a, out_data.code_bit_b,
                                out_data.code_bit_c, out_data.last_of_block);
                        mismatches++;
                    end
                end
            end
            triples_checked <= results_seen;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct)
            begin
                rx_gap = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int          n;
        int          len;
        logic [47:0] msg;
        // edge values, both CRC modes, clamped lengths, odd lengths
        add_item(48'h0, 6, 1'b0, 16'h0000, 1'b0);
        add_item(48'hffff_ffff_ffff, 48, 1'b0, 16'h0000, 1'b0);
        add_item(48'hffff_ffff_ffff, 48, 1'b1, 16'hffff, 1'b0);
        add_item(48'h0, 48, 1'b1, 16'h0000, 1'b0);
        add_item(48'h0, 6, 1'b1, 16'hffff, 1'b0);
        add_item(48'hb4c3_5a96_0f1e, 0, 1'b1, 16'h1234, 1'b0);
        add_item(48'hf800_0000_0000, 5, 1'b0, 16'h0000, 1'b0);
        add_item(48'h8000_0000_0000, 1, 1'b1, 16'h8001, 1'b0);
        add_item(48'h1234_5678_9abc, 49, 1'b0, 16'h0000, 1'b0);
        add_item(48'hfedc_ba98_7654, 63, 1'b1, 16'ha5a5, 1'b0);
        add_item(48'hc3a5_0000_0000, 7, 1'b1, 16'h00ff, 1'b0);
        add_item(48'h5aff_0000_0000, 8, 1'b1, 16'hff00, 1'b0);
        add_item(48'h9d80_0000_0000, 9, 1'b1, 16'h0f0f, 1'b0);
        add_item(48'hbeef_0000_0000, 16, 1'b0, 16'h0000, 1'b0);
        add_item(48'hcafe_ba00_0000, 24, 1'b1, 16'hbeef, 1'b0);
        add_item(48'hdead_beef_0000, 32, 1'b1, 16'h0001, 1'b0);
        add_item(48'h0123_4567_8900, 40, 1'b0, 16'h0000, 1'b0);
        add_item(48'haaaa_aaaa_aaaa, 47, 1'b1, 16'h5555, 1'b0);
        add_item(48'h8000_0000_0000, 48, 1'b1, 16'h0000, 1'b0);
        add_item(48'h0000_0000_0001, 48, 1'b1, 16'h0000, 1'b0);
        add_item(48'h5555_5555_5555, 33, 1'b0, 16'hffff, 1'b0);
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, 5);
                1: len = $urandom_range(49, 63);
                default: len = $urandom_range(6, 48);
            endcase
            msg = {$urandom(), 16'($urandom())};
            add_item(msg, len, 1'($urandom_range(0, 1)), 16'($urandom()),
                     n == 0 || n == 100);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        while (!inputs_done)
            @(posedge clk);
        while (triples_checked != triples_predicted)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_triples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
src/tbcc_pkg.sv
src/tbcc_ctrl.sv
src/tbcc_datapath.sv
src/tail_biting_conv_encoder_crc.sv
verif/tail_biting_conv_encoder_crc_test.sv
